@@ hdl/luma_false_color_mapper_defines.svh @@
// Assertion macros shared by the luma false color mapper RTL.
// Depends on nothing; the user supplies clk and rst_n in scope.
`ifndef LUMA_FALSE_COLOR_MAPPER_DEFINES_SVH
`define LUMA_FALSE_COLOR_MAPPER_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define LFC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define LFC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hdl/lfc_pkg.sv @@
// Package for the luma false color mapper: widths, coefficients, palette codes
// and the palette mapping function. Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package lfc_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned MODE_W = 3;

  // Luma weights in 1/65536 units; they sum to 65536.
  localparam int unsigned COEF_W = 16;
  localparam logic [COEF_W-1:0] COEF_R = 16'd19595;
  localparam logic [COEF_W-1:0] COEF_G = 16'd38470;
  localparam logic [COEF_W-1:0] COEF_B = 16'd7471;

  // Product widths follow from coefficient magnitude times 255.
  localparam int unsigned RP_W  = 23;
  localparam int unsigned GP_W  = 24;
  localparam int unsigned BP_W  = 21;
  localparam int unsigned SUM_W = COEF_W + PIX_W;

  // Palette selector codes. Six and seven wrap to iron and rainbow.
  localparam logic [MODE_W-1:0] PAL_IRON        = 3'd0;
  localparam logic [MODE_W-1:0] PAL_RAINBOW     = 3'd1;
  localparam logic [MODE_W-1:0] PAL_ARCTIC      = 3'd2;
  localparam logic [MODE_W-1:0] PAL_LAVA        = 3'd3;
  localparam logic [MODE_W-1:0] PAL_BLACK_HOT   = 3'd4;
  localparam logic [MODE_W-1:0] PAL_WHITE_HOT   = 3'd5;
  localparam logic [MODE_W-1:0] PAL_IRON_WRAP    = 3'd6;
  localparam logic [MODE_W-1:0] PAL_RAINBOW_WRAP = 3'd7;

  localparam logic [MODE_W-1:0] PAL_RESET = PAL_IRON;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
  } rgb_t;

  localparam logic [PIX_W-1:0] LVL_MAX = {PIX_W{1'b1}};
  localparam logic [PIX_W-1:0] LVL_MIN = '0;

  // Maps one luma level through the selected palette.
  function automatic rgb_t map_level(input logic [PIX_W-1:0] v,
                                     input logic [MODE_W-1:0] mode);
    rgb_t             res;
    logic [PIX_W-1:0] ramp;
    ramp = {v[PIX_W-3:0], 2'b00};
    res  = '0;
    unique case (mode)
      PAL_IRON, PAL_IRON_WRAP: begin
        res.r = v[PIX_W-1] ? LVL_MAX : {v[PIX_W-2:0], 1'b0};
        res.g = v[PIX_W-1] ? {v[PIX_W-2:0], 1'b0} : LVL_MIN;
        res.b = LVL_MIN;
      end
      PAL_RAINBOW, PAL_RAINBOW_WRAP: begin
        unique case (v[PIX_W-1:PIX_W-2])
          2'b00: begin
            res.r = LVL_MIN;
            res.g = LVL_MIN;
            res.b = ramp;
          end
          2'b01: begin
            res.r = LVL_MIN;
            res.g = ramp;
            res.b = ~ramp;
          end
          2'b10: begin
            res.r = ramp;
            res.g = ~ramp;
            res.b = LVL_MIN;
          end
          default: begin
            res.r = LVL_MAX;
            res.g = ramp;
            res.b = ramp;
          end
        endcase
      end
      PAL_ARCTIC: begin
        res.r = v >> 1;
        res.g = v;
        res.b = LVL_MAX;
      end
      PAL_LAVA: begin
        res.r = v;
        res.g = v >> 2;
        res.b = LVL_MIN;
      end
      PAL_BLACK_HOT: begin
        res.r = ~v;
        res.g = ~v;
        res.b = ~v;
      end
      default: begin
        res.r = v;
        res.g = v;
        res.b = v;
      end
    endcase
    return res;
  endfunction

endpackage

`default_nettype wire

@@ hdl/lfc_ifs.sv @@
// Stream interfaces of the luma false color mapper: source pixel in, mapped
// pixel out, each with valid/ready. Depends on lfc_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface lfc_in_if import lfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_in;
  logic [PIX_W-1:0] green_in;
  logic [PIX_W-1:0] blue_in;
  logic             inside_image;

  modport source (output valid, red_in, green_in, blue_in, inside_image, input ready);
  modport sink   (input valid, red_in, green_in, blue_in, inside_image, output ready);
endinterface

interface lfc_out_if import lfc_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] red_out;
  logic [PIX_W-1:0] green_out;
  logic [PIX_W-1:0] blue_out;

  modport source (output valid, red_out, green_out, blue_out, input ready);
  modport sink   (input valid, red_out, green_out, blue_out, output ready);
endinterface

`default_nettype wire

@@ hdl/luma_false_color_mapper.sv @@
// Top level of the luma false color mapper: a three stage pixel pipeline.
// Depends on lfc_pkg, lfc_ifs and luma_false_color_mapper_defines.svh.
//
// Usage:
// Source pixels arrive on in_pix (valid/ready), one item per pixel with
// 8-bit red, green and blue plus an inside_image flag. Mapped pixels leave
// on out_pix (valid/ready), one item per input item, in order.
// Stage one forms the three weighted products, stage two sums them and keeps
// the top byte as luma, stage three maps luma through the palette into the
// output register, which drives out_pix. Throughput is one item per cycle
// while the receiver takes every item.
// A pixel with inside_image low comes out black in every palette.
// cfg_we/cfg_wdata write the palette selector; write it only while the
// pipeline is empty. Codes six and seven act as iron and rainbow.
// Reset (rst_n low, synchronous) empties every stage and selects iron.
// When the receiver stalls, the output holds and each stage keeps its item
// until the one after it frees up, so empty stages still fill; in_pix.ready
// drops only once all three stages hold an item.
`timescale 1ns / 1ps
`default_nettype none
`include "luma_false_color_mapper_defines.svh"

module luma_false_color_mapper
  import lfc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  lfc_in_if.sink                 in_pix,
  lfc_out_if.source              out_pix,
  input  wire logic              cfg_we,
  input  wire logic [MODE_W-1:0] cfg_wdata
);

  // Palette selector register.
  logic [MODE_W-1:0] mode_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= PAL_RESET;
    end else if (cfg_we) begin
      mode_r <= cfg_wdata;
    end
  end

  // Stage enables: a stage loads when it is empty or its item moves on.
  logic en1;
  logic en2;
  logic en3;
  logic v1_r;
  logic v2_r;
  logic v3_r;

  assign en3 = !v3_r || out_pix.ready;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_pix.ready = en1;

  // Stage one: weighted products.
  logic [RP_W-1:0] rp_r;
  logic [GP_W-1:0] gp_r;
  logic [BP_W-1:0] bp_r;
  logic            inside1_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
    end else if (en1) begin
      v1_r <= in_pix.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      rp_r      <= RP_W'(in_pix.red_in)   * RP_W'(COEF_R);
      gp_r      <= GP_W'(in_pix.green_in) * GP_W'(COEF_G);
      bp_r      <= BP_W'(in_pix.blue_in)  * BP_W'(COEF_B);
      inside1_r <= in_pix.inside_image;
    end
  end

  // Stage two: sum of products, top byte is luma. The weights add to 65536,
  // so the sum never exceeds SUM_W bits.
  logic [SUM_W-1:0] sum_nxt;
  logic [PIX_W-1:0] luma_r;
  logic             inside2_r;

  assign sum_nxt = SUM_W'(rp_r) + SUM_W'(gp_r) + SUM_W'(bp_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v2_r <= 1'b0;
    end else if (en2) begin
      v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en2) begin
      luma_r    <= sum_nxt[SUM_W-1:SUM_W-PIX_W];
      inside2_r <= inside1_r;
    end
  end

  // Stage three: palette map, black outside the image.
  rgb_t pix_nxt;
  rgb_t pix_r;

  assign pix_nxt = inside2_r ? map_level(luma_r, mode_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
    end else if (en3) begin
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en3) begin
      pix_r <= pix_nxt;
    end
  end

  assign out_pix.valid     = v3_r;
  assign out_pix.red_out   = pix_r.r;
  assign out_pix.green_out = pix_r.g;
  assign out_pix.blue_out  = pix_r.b;

  // Checks on the pipeline control and the mapping.
  `LFC_ASSERT_SAME(a_full_when_blocked, !in_pix.ready, v1_r && v2_r && v3_r, "ready low with a free stage")
  `LFC_ASSERT_NEXT(a_enter_stage1, in_pix.valid && in_pix.ready, v1_r, "accepted item missing from stage one")
  `LFC_ASSERT_NEXT(a_stage2_hold, v2_r && !en3, v2_r && $stable(luma_r), "stalled luma item lost or changed")
  `LFC_ASSERT_NEXT(a_outside_black, v2_r && en3 && !inside2_r, (out_pix.red_out == '0) && (out_pix.green_out == '0) && (out_pix.blue_out == '0), "outside pixel not black")
  `LFC_ASSERT_NEXT(a_gray_palettes, v2_r && en3 && inside2_r && ((mode_r == PAL_BLACK_HOT) || (mode_r == PAL_WHITE_HOT)), (out_pix.red_out == out_pix.green_out) && (out_pix.green_out == out_pix.blue_out), "gray palette gave a colored pixel")

endmodule

`default_nettype wire

@@ tb/sv/luma_false_color_mapper_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for luma_false_color_mapper: a queue-fed driver and a
// checking monitor. It predicts each mapped pixel from the source pixel and
// the palette. Depends on lfc_pkg, lfc_ifs and the mapper RTL.

module luma_false_color_mapper_test;
  import lfc_pkg::*;

  // The run is over well before this; reaching it means the pipeline hung.
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned ITEMS_PER_SET = 225;
  localparam int unsigned HOLD_CYCLES   = 300;
  // Three pipeline stages plus some slack for the drain at the end.
  localparam int unsigned DRAIN_CYCLES  = 8;

  typedef struct packed {
    logic [PIX_W-1:0] r;
    logic [PIX_W-1:0] g;
    logic [PIX_W-1:0] b;
    logic             in_image;
  } src_pixel_t;

  logic              clk;
  logic              rst_n;
  logic              cfg_we;
  logic [MODE_W-1:0] cfg_wdata;

  lfc_in_if  in_pix ();
  lfc_out_if out_pix ();

  luma_false_color_mapper dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_pix   (in_pix),
    .out_pix  (out_pix),
    .cfg_we   (cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  // Source pixels waiting to be offered, and mapped pixels we expect back,
  // oldest first.
  src_pixel_t  pending_pixels[$];
  rgb_t        expected_pixels[$];

  // Our own copy of the palette register, updated on every write we make.
  logic [MODE_W-1:0] palette_sel;

  int unsigned send_idle_pct;
  int unsigned stall_pct;
  logic        hold_off;
  int unsigned error_count;
  int unsigned cycle_count;

  // Luma in 0..255: the three weights sum to 65536, so a gray pixel of level
  // v gives back exactly v.
  function automatic logic [PIX_W-1:0] luma_level(input src_pixel_t p);
    int unsigned acc;
    acc = 19595 * p.r + 38470 * p.g + 7471 * p.b;
    return PIX_W'((acc >> 16) & 8'hFF);
  endfunction

  // Expected mapped pixel for one source pixel under the given selector.
  function automatic rgb_t predict_mapped_pixel(input src_pixel_t p,
                                                input logic [MODE_W-1:0] sel);
    rgb_t              res;
    int unsigned       v;
    logic [MODE_W-1:0] pal;
    res = '0;
    v   = luma_level(p);
    // Selector codes six and seven fold back onto iron and rainbow.
    pal = sel;
    if (pal == PAL_IRON_WRAP) pal = PAL_IRON;
    if (pal == PAL_RAINBOW_WRAP) pal = PAL_RAINBOW;
    if (!p.in_image) return res;
    case (pal)
      PAL_IRON: begin
        res.r = (v < 128) ? PIX_W'(2 * v) : 8'd255;
        res.g = (v < 128) ? 8'd0 : PIX_W'(2 * (v - 128));
        res.b = 8'd0;
      end
      PAL_RAINBOW: begin
        if (v < 64) begin
          res.b = PIX_W'(4 * v);
        end else if (v < 128) begin
          res.g = PIX_W'(4 * (v - 64));
          res.b = PIX_W'(255 - 4 * (v - 64));
        end else if (v < 192) begin
          res.r = PIX_W'(4 * (v - 128));
          res.g = PIX_W'(255 - 4 * (v - 128));
        end else begin
          res.r = 8'd255;
          res.g = PIX_W'(4 * (v - 192));
          res.b = PIX_W'(4 * (v - 192));
        end
      end
      PAL_ARCTIC: begin
        res.r = PIX_W'(v / 2);
        res.g = PIX_W'(v);
        res.b = 8'd255;
      end
      PAL_LAVA: begin
        res.r = PIX_W'(v);
        res.g = PIX_W'(v / 4);
      end
      PAL_BLACK_HOT: begin
        res.r = PIX_W'(255 - v);
        res.g = res.r;
        res.b = res.r;
      end
      default: begin
        res.r = PIX_W'(v);
        res.g = PIX_W'(v);
        res.b = PIX_W'(v);
      end
    endcase
    return res;
  endfunction

  // Mostly ordinary pixels, some outside the image, and a share of grays so
  // that the palette segment edges (63/64, 127/128, 191/192) are hit often.
  function automatic src_pixel_t make_random_pixel();
    src_pixel_t  p;
    int unsigned pick;
    int unsigned lvl;
    logic [PIX_W-1:0] edges[8];
    edges = '{8'd0, 8'd63, 8'd64, 8'd127, 8'd128, 8'd191, 8'd192, 8'd255};
    pick  = $urandom_range(99);
    p.r        = PIX_W'($urandom);
    p.g        = PIX_W'($urandom);
    p.b        = PIX_W'($urandom);
    p.in_image = (pick >= 10);
    if (pick >= 75) begin
      lvl = $urandom_range(1) ? edges[$urandom_range(7)] : $urandom_range(255);
      p.r = PIX_W'(lvl);
      p.g = PIX_W'(lvl);
      p.b = PIX_W'(lvl);
    end
    return p;
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Driver: offers the next pending pixel whenever the bus is free, and
  // records the expected result at the edge where an item is taken.
  always @(posedge clk) begin
    src_pixel_t nxt;
    if (!rst_n) begin
      in_pix.valid <= 1'b0;
    end else begin
      if (in_pix.valid && in_pix.ready) begin
        expected_pixels.push_back(predict_mapped_pixel(
          '{in_pix.red_in, in_pix.green_in, in_pix.blue_in, in_pix.inside_image},
          palette_sel));
      end
      if (!in_pix.valid || in_pix.ready) begin
        if (pending_pixels.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          nxt = pending_pixels.pop_front();
          in_pix.valid        <= 1'b1;
          in_pix.red_in       <= nxt.r;
          in_pix.green_in     <= nxt.g;
          in_pix.blue_in      <= nxt.b;
          in_pix.inside_image <= nxt.in_image;
        end else begin
          in_pix.valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: checks every accepted result against the oldest expectation,
  // then picks the ready level for the next cycle.
  always @(posedge clk) begin
    rgb_t want;
    if (!rst_n) begin
      out_pix.ready <= 1'b0;
    end else begin
      if (out_pix.valid && out_pix.ready) begin
        if (expected_pixels.size() == 0) begin
          $error("result with no item outstanding: r=%0d g=%0d b=%0d",
                 out_pix.red_out, out_pix.green_out, out_pix.blue_out);
          error_count++;
        end else begin
          want = expected_pixels.pop_front();
          if (out_pix.red_out !== want.r) begin
            $error("red_out: expected %0d, got %0d", want.r, out_pix.red_out);
            error_count++;
          end
          if (out_pix.green_out !== want.g) begin
            $error("green_out: expected %0d, got %0d", want.g, out_pix.green_out);
            error_count++;
          end
          if (out_pix.blue_out !== want.b) begin
            $error("blue_out: expected %0d, got %0d", want.b, out_pix.blue_out);
            error_count++;
          end
        end
      end
      out_pix.ready <= !hold_off && ($urandom_range(99) >= stall_pct);
    end
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("** luma_false_color_mapper: FAILED **");
      $finish;
    end
  end

  // Returns once every pixel has been offered, taken and checked. The state
  // is sampled a little after the edge, once the driver and monitor have
  // finished their updates for that edge.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (pending_pixels.size() != 0 || in_pix.valid || expected_pixels.size() != 0);
  endtask

  // Writes the palette register; only called while the pipeline is empty.
  task automatic write_palette(input logic [MODE_W-1:0] sel);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= sel;
    @(posedge clk);
    cfg_we    <= 1'b0;
    palette_sel = sel;
  endtask

  // Sets both sides' idling for the next stretch of traffic.
  task automatic set_idling(input int unsigned phase);
    @(posedge clk);
    case (phase % 4)
      0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
      1: begin send_idle_pct <= 51; stall_pct <= 0;  end
      2: begin send_idle_pct <= 0;  stall_pct <= 51; end
      default: begin send_idle_pct <= 12; stall_pct <= 12; end
    endcase
  endtask

  initial begin
    logic [MODE_W-1:0] sel_order[8];
    sel_order = '{PAL_WHITE_HOT, PAL_RAINBOW, PAL_ARCTIC, PAL_LAVA,
                  PAL_BLACK_HOT, PAL_IRON_WRAP, PAL_RAINBOW_WRAP, PAL_IRON};

    // Every input is known from time zero.
    rst_n               = 1'b0;
    cfg_we              = 1'b0;
    cfg_wdata           = '0;
    in_pix.valid        = 1'b0;
    in_pix.red_in       = '0;
    in_pix.green_in     = '0;
    in_pix.blue_in      = '0;
    in_pix.inside_image = 1'b0;
    out_pix.ready       = 1'b0;
    palette_sel         = PAL_RESET;
    send_idle_pct       = 0;
    stall_pct           = 0;
    hold_off            = 1'b0;
    error_count         = 0;
    cycle_count         = 0;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // Directed pixels under the reset palette: a bright pixel outside the
    // image must come out black, then the extremes, the primaries and grays
    // on both sides of each rainbow segment edge.
    pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b0});
    pending_pixels.push_back('{8'd0,   8'd0,   8'd0,   1'b0});
    pending_pixels.push_back('{8'd0,   8'd0,   8'd0,   1'b1});
    pending_pixels.push_back('{8'd255, 8'd255, 8'd255, 1'b1});
    pending_pixels.push_back('{8'd255, 8'd0,   8'd0,   1'b1});
    pending_pixels.push_back('{8'd0,   8'd255, 8'd0,   1'b1});
    pending_pixels.push_back('{8'd0,   8'd0,   8'd255, 1'b1});
    pending_pixels.push_back('{8'd255, 8'd0,   8'd255, 1'b1});
    pending_pixels.push_back('{8'd170, 8'd85,  8'd170, 1'b1});
    pending_pixels.push_back('{8'd85,  8'd170, 8'd85,  1'b1});
    pending_pixels.push_back('{8'd63,  8'd63,  8'd63,  1'b1});
    pending_pixels.push_back('{8'd64,  8'd64,  8'd64,  1'b1});
    pending_pixels.push_back('{8'd127, 8'd127, 8'd127, 1'b1});
    pending_pixels.push_back('{8'd128, 8'd128, 8'd128, 1'b1});
    pending_pixels.push_back('{8'd191, 8'd191, 8'd191, 1'b1});
    pending_pixels.push_back('{8'd192, 8'd192, 8'd192, 1'b1});
    wait_drained();

    // One random set per selector value, including the two that wrap. The
    // idling pattern rotates from set to set.
    for (int unsigned k = 0; k < 8; k++) begin
      repeat (DRAIN_CYCLES) @(posedge clk);
      write_palette(sel_order[k]);
      set_idling(k);
      for (int unsigned n = 0; n < ITEMS_PER_SET; n++)
        pending_pixels.push_back(make_random_pixel());

      // In the first set the receiver stops for a long stretch while the
      // sender keeps offering, so all three stages fill and in_pix.ready
      // has to drop.
      if (k == 0) begin
        repeat (20) @(posedge clk);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
      end
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("** luma_false_color_mapper: PASSED **");
    end else begin
      $display("** luma_false_color_mapper: FAILED **");
    end
    $finish;
  end

endmodule

@@ luma_false_color_mapper.f @@
+incdir+hdl
hdl/lfc_pkg.sv
hdl/lfc_ifs.sv
hdl/luma_false_color_mapper.sv
tb/sv/luma_false_color_mapper_test.sv
